/* hw/rtl/binary_min_heap_top_assert.svh */
// assertion macros for the binary min-heap block
`ifndef BINARY_MIN_HEAP_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define BMH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("binary_min_heap_top: assertion failed");
// same-cycle implication
`define BMH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("binary_min_heap_top: implication failed");
// next-cycle implication
`define BMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("binary_min_heap_top: next-cycle implication failed");
`else
`define BMH_ASSERT(label, clk, rst, prop)
`define BMH_ASSERT_IMP(label, clk, rst, ante, cons)
`define BMH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/bmh_pkg.sv */
// shared types, codes and defaults of the binary min-heap block
`default_nettype none
package bmh_pkg;

   // default sizing
   localparam int CAPACITY_DEF  = 64;
   localparam int KEY_WIDTH_DEF = 32;

   // field widths of the request and response
   localparam int OPCODE_W    = 2;
   localparam int KEY_FIELD_W = 32;
   localparam int POS_W       = 6;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 7;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_INSERT     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_MIN = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_AT  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NOP        = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0]    opcode;
      logic [KEY_FIELD_W-1:0] key;
      logic [POS_W-1:0]       position;
   } bmh_req_type;

   typedef struct packed {
      logic [KEY_FIELD_W-1:0] removed_key;
      logic [STATUS_W-1:0]    status;
      logic [COUNT_W-1:0]     count;
   } bmh_rsp_type;

   // heap read address selection
   typedef enum logic [2:0] {
      RD_START,
      RD_LAST,
      RD_PARENT,
      RD_LEFT,
      RD_RIGHT
   } bmh_rd_sel_type;

   // heap write data selection
   typedef enum logic [1:0] {
      WR_X,
      WR_RDATA,
      WR_CHILD
   } bmh_wr_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic           load;
      logic           decode;
      logic           start_ins;
      logic           start_rem;
      logic           cap_removed;
      logic           cap_x;
      logic           rd_en;
      bmh_rd_sel_type rd_sel;
      logic           wr_en;
      bmh_wr_sel_type wr_sel;
      logic           hole_to_parent;
      logic           hole_to_child;
      logic           cap_left;
      logic           cap_right;
      logic           rsp_load;
   } bmh_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                err;
      logic                hole_zero;
      logic                last_slot;
      logic                x_lt_rdata;
      logic                left_in;
      logic                right_in;
      logic                rdata_lt_child;
      logic                x_lt_child;
   } bmh_stat_type;

endpackage
`default_nettype wire

/* hw/rtl/binary_min_heap_top.sv */
// top level of the binary min-heap priority queue
`default_nettype none
`include "binary_min_heap_top_assert.svh"
// Binary min-heap of unsigned keys held in one RAM of CAPACITY entries. Each
// request inserts a key, removes the minimum or removes the key at a heap
// position, and gives exactly one response with the removed key, a status and
// the element count. One request is worked on at a time; a new request is
// taken while the previous response still waits. A rejected or no-op request
// is answered straight after decode, and a remove that takes the last slot
// straight after the read of its key; an insert climbs u levels, and any other
// remove climbs u and descends d levels (u, d at most log2(CAPACITY)). After
// the response is loaded the block returns to idle, where the next request is
// taken; while an earlier response is still unaccepted, the finished request
// waits in its last state. The heap RAM gives one read per cycle with
// registered data, so a level of sift-up takes a read and a compare, and a
// level of sift-down a left read, a right read, a child choice and a compare.
module binary_min_heap_top #(
   parameter int CAPACITY  = bmh_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = bmh_pkg::KEY_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire bmh_pkg::bmh_req_type req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      bmh_pkg::bmh_rsp_type rsp_data
);
   import bmh_pkg::*;

   bmh_cmd_type  cmd;
   bmh_stat_type stat;

   bmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   bmh_dp #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );

   // one request in work at a time
   `BMH_ASSERT_NEXT(a_single_request, clock, reset, req_valid && req_ready, !req_ready)
   // a rejected request never returns a key
   `BMH_ASSERT_IMP(a_reject_no_key, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.removed_key == '0)
   // hole register updates never collide
   `BMH_ASSERT(a_hole_update_once, clock, reset, $onehot0({cmd.start_ins, cmd.start_rem, cmd.hole_to_parent, cmd.hole_to_child}))
   // a loaded response is presented next cycle
   `BMH_ASSERT_NEXT(a_rsp_after_load, clock, reset, cmd.rsp_load, rsp_valid)

endmodule
`default_nettype wire

/* hw/rtl/bmh_ram.sv */
// generic single-write, single-read RAM with registered read data
`default_nettype none
module bmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/bmh_ctrl.sv */
// sequencing state machine of the binary min-heap
`default_nettype none
module bmh_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      bmh_pkg::bmh_cmd_type  cmd,
   input  wire bmh_pkg::bmh_stat_type stat
);
   import bmh_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_RM_ROOT,
      S_RM_LAST,
      S_UP_CHK,
      S_UP_CMP,
      S_DN_CHK,
      S_DN_L,
      S_DN_R,
      S_DN_CMP,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.rd_sel   = RD_START;
      cmd.wr_sel   = WR_X;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (stat.err || stat.op == OP_NOP) begin
               state_in = S_FINISH;
            end else if (stat.op == OP_INSERT) begin
               cmd.start_ins = 1'b1;
               state_in      = S_UP_CHK;
            end else begin
               // fetch the key being removed
               cmd.start_rem = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_START;
               state_in      = S_RM_ROOT;
            end
         end
         S_RM_ROOT: begin
            cmd.cap_removed = 1'b1;
            if (stat.last_slot) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in   = S_RM_LAST;
            end
         end
         S_RM_LAST: begin
            cmd.cap_x = 1'b1;
            state_in  = S_UP_CHK;
         end
         S_UP_CHK: begin
            if (!stat.hole_zero) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_CMP;
            end else if (stat.op == OP_INSERT) begin
               cmd.wr_en = 1'b1;
               state_in  = S_FINISH;
            end else begin
               state_in = S_DN_CHK;
            end
         end
         S_UP_CMP: begin
            if (stat.x_lt_rdata) begin
               // parent moves down into the hole
               cmd.wr_en          = 1'b1;
               cmd.wr_sel         = WR_RDATA;
               cmd.hole_to_parent = 1'b1;
               state_in           = S_UP_CHK;
            end else if (stat.op == OP_INSERT) begin
               cmd.wr_en = 1'b1;
               state_in  = S_FINISH;
            end else begin
               state_in = S_DN_CHK;
            end
         end
         S_DN_CHK: begin
            if (stat.left_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LEFT;
               state_in   = S_DN_L;
            end else begin
               cmd.wr_en = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_DN_L: begin
            cmd.cap_left = 1'b1;
            if (stat.right_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_RIGHT;
               state_in   = S_DN_R;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_R: begin
            // right child wins only when strictly smaller
            cmd.cap_right = stat.rdata_lt_child;
            state_in      = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.x_lt_child) begin
               cmd.wr_en = 1'b1;
               state_in  = S_FINISH;
            end else begin
               cmd.wr_en         = 1'b1;
               cmd.wr_sel        = WR_CHILD;
               cmd.hole_to_child = 1'b1;
               state_in          = S_DN_CHK;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* hw/rtl/bmh_dp.sv */
// heap datapath: request registers, hole and key registers, heap RAM
`default_nettype none
module bmh_dp #(
   parameter int CAPACITY  = bmh_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = bmh_pkg::KEY_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bmh_pkg::bmh_req_type req_data,
   output      bmh_pkg::bmh_rsp_type rsp_data,
   input  wire bmh_pkg::bmh_cmd_type cmd,
   output      bmh_pkg::bmh_stat_type stat
);
   import bmh_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int EXT_W  = IDX_W + 2;
   localparam int PCMP_W = (EXT_W > POS_W) ? EXT_W : POS_W;

   logic [OPCODE_W-1:0]    op_ff;
   logic [KEY_FIELD_W-1:0] key_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [IDX_W-1:0]       hole_ff;
   logic [IDX_W-1:0]       cidx_ff;
   logic [KEY_WIDTH-1:0]   x_ff;
   logic [KEY_WIDTH-1:0]   child_ff;
   logic [KEY_WIDTH-1:0]   removed_ff;
   logic [STATUS_W-1:0]    status_ff;
   bmh_rsp_type            rsp_ff;

   logic [STATUS_W-1:0]    err_code;
   logic                   full;
   logic                   empty;
   logic                   pos_out;
   logic [IDX_W-1:0]       start_idx;
   logic [IDX_W-1:0]       parent_idx;
   logic [EXT_W-1:0]       left_ext;
   logic [EXT_W-1:0]       right_ext;
   logic [EXT_W-1:0]       count_ext;
   logic [IDX_W-1:0]       rd_addr;
   logic [KEY_WIDTH-1:0]   wr_data;
   logic [KEY_WIDTH-1:0]   rd_data;

   // request checks
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign pos_out = (PCMP_W'(pos_ff) >= PCMP_W'(count_ff));

   always_comb begin
      case (op_ff)
         OP_INSERT:     err_code = full ? ST_FULL : ST_OK;
         OP_REMOVE_MIN: err_code = empty ? ST_EMPTY : ST_OK;
         OP_REMOVE_AT:  err_code = empty ? ST_EMPTY : (pos_out ? ST_RANGE : ST_OK);
         default:       err_code = ST_OK;
      endcase
   end

   // tree index arithmetic
   assign start_idx  = (op_ff == OP_REMOVE_MIN) ? '0 : IDX_W'(pos_ff);
   assign parent_idx = (hole_ff - IDX_W'(1)) >> 1;
   assign left_ext   = EXT_W'({hole_ff, 1'b1});
   assign right_ext  = left_ext + EXT_W'(1);
   assign count_ext  = EXT_W'(count_ff);

   // read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_START:  rd_addr = start_idx;
         RD_LAST:   rd_addr = count_ff[IDX_W-1:0];
         RD_PARENT: rd_addr = parent_idx;
         RD_LEFT:   rd_addr = left_ext[IDX_W-1:0];
         RD_RIGHT:  rd_addr = right_ext[IDX_W-1:0];
         default:   rd_addr = '0;
      endcase
   end

   // write data select, always written at the hole
   always_comb begin
      case (cmd.wr_sel)
         WR_X:     wr_data = x_ff;
         WR_RDATA: wr_data = rd_data;
         WR_CHILD: wr_data = child_ff;
         default:  wr_data = x_ff;
      endcase
   end

   bmh_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (hole_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // element count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.start_ins) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.start_rem) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   // request capture, sift registers and response
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.opcode;
         key_ff <= req_data.key;
         pos_ff <= req_data.position;
      end
      if (cmd.decode) begin
         status_ff  <= err_code;
         removed_ff <= '0;
      end
      if (cmd.cap_removed) begin
         removed_ff <= rd_data;
      end
      if (cmd.start_ins) begin
         x_ff    <= KEY_WIDTH'(key_ff);
         hole_ff <= count_ff[IDX_W-1:0];
      end else if (cmd.start_rem) begin
         hole_ff <= start_idx;
      end else if (cmd.hole_to_parent) begin
         hole_ff <= parent_idx;
      end else if (cmd.hole_to_child) begin
         hole_ff <= cidx_ff;
      end
      if (cmd.cap_x) begin
         x_ff <= rd_data;
      end
      if (cmd.cap_left) begin
         child_ff <= rd_data;
         cidx_ff  <= left_ext[IDX_W-1:0];
      end else if (cmd.cap_right) begin
         child_ff <= rd_data;
         cidx_ff  <= right_ext[IDX_W-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_ff.removed_key <= KEY_FIELD_W'(removed_ff);
         rsp_ff.status      <= status_ff;
         rsp_ff.count       <= COUNT_W'(count_ff);
      end
   end

   // status to the controller
   assign stat.op             = op_ff;
   assign stat.err            = (err_code != ST_OK);
   assign stat.hole_zero      = (hole_ff == '0);
   assign stat.last_slot      = (CNT_W'(hole_ff) == count_ff);
   assign stat.x_lt_rdata     = (x_ff < rd_data);
   assign stat.left_in        = (left_ext < count_ext);
   assign stat.right_in       = (right_ext < count_ext);
   assign stat.rdata_lt_child = (rd_data < child_ff);
   assign stat.x_lt_child     = (x_ff < child_ff);

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire
